### rtl/frustum_cull_test_unit_macros.svh
// Assertion macros shared by the frustum cull test unit.
`ifndef FRUSTUM_CULL_TEST_UNIT_MACROS_SVH
`define FRUSTUM_CULL_TEST_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define FCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fct_pkg.sv
// Shared constants and types for the frustum cull test unit.
package fct_pkg;

    localparam int NUM_PLANES = 4;
    localparam int NUM_VERTS  = 3;
    localparam int NUM_AXES   = 3;
    localparam int NORM_W     = 16;
    localparam int OFFS_W     = 32;
    localparam int FRAC_SHIFT = 14;

    // APB register file geometry
    localparam int APB_DW = 64;
    localparam int APB_AW = 6;

    // Register kind, selected by paddr[3]
    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_OFFSET = 1'b1;

    // Test kinds
    localparam logic [1:0] OP_POINT    = 2'd0;
    localparam logic [1:0] OP_SPHERE   = 2'd1;
    localparam logic [1:0] OP_TRIANGLE = 2'd2;

    // Visibility codes
    localparam logic [1:0] VIS_OUTSIDE  = 2'd0;
    localparam logic [1:0] VIS_PARTIAL  = 2'd1;
    localparam logic [1:0] VIS_INSIDE   = 2'd2;
    localparam logic [1:0] VIS_RESERVED = 2'd3;

    typedef logic [NUM_PLANES-1:0] fct_code_t;

    // Load enables for the distance pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } fct_stage_en_t;

endpackage

### rtl/fct_prim_if.sv
// Request channel carrying one primitive to be tested.
interface fct_prim_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] margin;

    modport source (
        output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, margin,
        input  ready
    );
    modport sink (
        input  valid, op, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, margin,
        output ready
    );
endinterface

### rtl/fct_result_if.sv
// Result channel carrying the visibility class.
interface fct_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (
        output valid, visibility,
        input  ready
    );
    modport sink (
        input  valid, visibility,
        output ready
    );
endinterface

### rtl/fct_dist_pipe.sv
// Three-stage signed plane distance: products, partial sums, final sum.
module fct_dist_pipe
    import fct_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int DIST_W     = 48
) (
    input  logic                         clk,
    input  fct_stage_en_t                en,
    input  logic [3*NORM_W-1:0]          normal,
    input  logic signed [OFFS_W-1:0]     offset,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    output logic signed [DIST_W-1:0]     dist_out
);

    localparam int PROD_W = NORM_W + COORD_BITS;

    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [PROD_W-1:0] prod_reg [NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_AXES];
    logic signed [DIST_W-1:0] pair_reg, pair_next;
    logic signed [DIST_W-1:0] rest_reg, rest_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;

    assign nx = $signed(normal[NORM_W-1:0]);
    assign ny = $signed(normal[2*NORM_W-1:NORM_W]);
    assign nz = $signed(normal[3*NORM_W-1:2*NORM_W]);

    // Stage 1: one multiplier per axis
    always_comb
    begin
        prod_next[0] = nx * px;
        prod_next[1] = ny * py;
        prod_next[2] = nz * pz;
    end

    // Stage 2: x+y, and z plus offset aligned to 14 fraction bits
    always_comb
    begin
        pair_next = DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1]);
        rest_next = DIST_W'(prod_reg[2]) + (DIST_W'(offset) <<< FRAC_SHIFT);
    end

    // Stage 3: final sum
    assign dist_next = pair_reg + rest_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_next;
        end
        if (en.s2)
        begin
            pair_reg <= pair_next;
            rest_reg <= rest_next;
        end
        if (en.s3)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

### rtl/frustum_cull_test_unit.sv
// Pipeline: 5 register stages (3 distance stages, one compare stage, one output
// register). Throughput: one request per cycle while results are taken; each
// stage holds its item while the next stage is full, so a stalled result only
// stops the stages behind it.
// Reset: rst_n (async, active low) empties the pipeline and clears all plane
// registers to zero.
`include "frustum_cull_test_unit_macros.svh"

// Top level: APB plane registers, 12 distance pipes and classification.
module frustum_cull_test_unit
    import fct_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    fct_prim_if.sink            prim,
    fct_result_if.source        result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int DIST_W = (COORD_BITS + 18 > OFFS_W + FRAC_SHIFT + 2) ?
                            (COORD_BITS + 18) : (OFFS_W + FRAC_SHIFT + 2);
    localparam int STAGES = 5;

    // ------------------------------------------------------------------
    // Plane registers
    // ------------------------------------------------------------------
    logic [3*NORM_W-1:0]      normal_reg [NUM_PLANES];
    logic signed [OFFS_W-1:0] offset_reg [NUM_PLANES];
    logic [1:0]               reg_plane;
    logic                     reg_kind;
    logic                     reg_wr;

    assign reg_plane = paddr[5:4];
    assign reg_kind  = paddr[3];
    assign reg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                normal_reg[i] <= '0;
                offset_reg[i] <= '0;
            end
        end
        else if (reg_wr)
        begin
            if (reg_kind == KIND_NORMAL)
                normal_reg[reg_plane] <= pwdata[3*NORM_W-1:0];
            else
                offset_reg[reg_plane] <= pwdata[OFFS_W-1:0];
        end
    end

    // Read back, zero extended
    always_comb
    begin
        if (reg_kind == KIND_OFFSET)
            prdata = {{(APB_DW-OFFS_W){1'b0}}, offset_reg[reg_plane]};
        else
            prdata = {{(APB_DW-3*NORM_W){1'b0}}, normal_reg[reg_plane]};
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [STAGES-1:0] v_reg, v_next;
    logic [STAGES-1:0] rdy;
    fct_stage_en_t     dist_en;

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || result.ready;
        for (int s = STAGES-2; s >= 0; s--)
            rdy[s] = !v_reg[s] || rdy[s+1];
    end

    always_comb
    begin
        v_next = v_reg;
        if (rdy[0])
            v_next[0] = prim.valid;
        for (int s = 1; s < STAGES; s++)
        begin
            if (rdy[s])
                v_next[s] = v_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign prim.ready = rdy[0];
    assign dist_en.s1 = rdy[0];
    assign dist_en.s2 = rdy[1];
    assign dist_en.s3 = rdy[2];

    // ------------------------------------------------------------------
    // Distance pipes: one per vertex and plane
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] vert [NUM_VERTS][NUM_AXES];
    logic signed [DIST_W-1:0]     plane_dist [NUM_VERTS][NUM_PLANES];

    assign vert[0][0] = prim.a_x;
    assign vert[0][1] = prim.a_y;
    assign vert[0][2] = prim.a_z;
    assign vert[1][0] = prim.b_x;
    assign vert[1][1] = prim.b_y;
    assign vert[1][2] = prim.b_z;
    assign vert[2][0] = prim.c_x;
    assign vert[2][1] = prim.c_y;
    assign vert[2][2] = prim.c_z;

    for (genvar k = 0; k < NUM_VERTS; k++)
    begin : g_vert
        for (genvar i = 0; i < NUM_PLANES; i++)
        begin : g_plane
            fct_dist_pipe #(
                .COORD_BITS (COORD_BITS),
                .DIST_W     (DIST_W)
            ) u_dist (
                .clk      (clk),
                .en       (dist_en),
                .normal   (normal_reg[i]),
                .offset   (offset_reg[i]),
                .px       (vert[k][0]),
                .py       (vert[k][1]),
                .pz       (vert[k][2]),
                .dist_out (plane_dist[k][i])
            );
        end
    end

    // ------------------------------------------------------------------
    // Sideband: op and margin travel alongside the distance stages
    // ------------------------------------------------------------------
    logic [1:0]                   op_s1_reg, op_s2_reg, op_s3_reg, op_s4_reg;
    logic signed [COORD_BITS-1:0] margin_s1_reg, margin_s2_reg, margin_s3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            op_s1_reg     <= prim.op;
            margin_s1_reg <= prim.margin;
        end
        if (rdy[1])
        begin
            op_s2_reg     <= op_s1_reg;
            margin_s2_reg <= margin_s1_reg;
        end
        if (rdy[2])
        begin
            op_s3_reg     <= op_s2_reg;
            margin_s3_reg <= margin_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: compares against zero and the scaled margin
    // ------------------------------------------------------------------
    logic signed [DIST_W-1:0] m_scaled, m_neg;
    fct_code_t                code_next [NUM_VERTS];
    fct_code_t                code_s4_reg [NUM_VERTS];
    logic                     pos_any_next, pos_any_s4_reg;
    logic                     all_in_next, all_in_s4_reg;

    always_comb
    begin
        m_scaled     = DIST_W'(margin_s3_reg) <<< FRAC_SHIFT;
        m_neg        = -m_scaled;
        pos_any_next = 1'b0;
        all_in_next  = 1'b1;
        for (int k = 0; k < NUM_VERTS; k++)
            for (int i = 0; i < NUM_PLANES; i++)
                code_next[k][i] = plane_dist[k][i] > m_scaled;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if (plane_dist[0][i] > 0)
                pos_any_next = 1'b1;
            if (!(plane_dist[0][i] < m_neg))
                all_in_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            op_s4_reg      <= op_s3_reg;
            code_s4_reg    <= code_next;
            pos_any_s4_reg <= pos_any_next;
            all_in_s4_reg  <= all_in_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: classification into the output register
    // ------------------------------------------------------------------
    logic [1:0] vis_reg, vis_next;
    fct_code_t  code_or, code_and;

    assign code_or  = code_s4_reg[0] | code_s4_reg[1] | code_s4_reg[2];
    assign code_and = code_s4_reg[0] & code_s4_reg[1] & code_s4_reg[2];

    always_comb
    begin
        case (op_s4_reg)
            OP_POINT:
                vis_next = pos_any_s4_reg ? VIS_OUTSIDE : VIS_INSIDE;
            OP_SPHERE:
                if (|code_s4_reg[0])
                    vis_next = VIS_OUTSIDE;
                else if (all_in_s4_reg)
                    vis_next = VIS_INSIDE;
                else
                    vis_next = VIS_PARTIAL;
            OP_TRIANGLE:
                if (code_or == '0)
                    vis_next = VIS_INSIDE;
                else if (code_and != '0)
                    vis_next = VIS_OUTSIDE;
                else
                    vis_next = VIS_PARTIAL;
            default:
                vis_next = VIS_OUTSIDE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
            vis_reg <= vis_next;
    end

    assign result.valid      = v_reg[STAGES-1];
    assign result.visibility = vis_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FCT_ASSERT_NEXT(a_accept_enters, prim.valid && prim.ready, v_reg[0],
        "accepted request did not enter stage 1")
    `FCT_ASSERT_NEXT(a_stage4_holds, v_reg[3] && !rdy[4], v_reg[3],
        "stage 4 item lost while output stalled")
    `FCT_ASSERT_NOW(a_vis_code, result.valid, result.visibility != VIS_RESERVED,
        "reserved visibility code on result")
    `FCT_ASSERT_NOW(a_point_no_partial, v_reg[3] && op_s4_reg == OP_POINT,
        vis_next != VIS_PARTIAL, "point test classified as partial")

endmodule

### bench/cull_checker.sv
// Checker for the frustum cull unit: tracks plane writes, predicts visibility, compares results.
module cull_checker
    import fct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fct_prim_if               prim,
    fct_result_if             result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                fail_count,
    output int                pending,
    output int                seen_outside,
    output int                seen_partial,
    output int                seen_inside
);

    // offsets and margins are lifted onto the 14-bit fraction grid of the products
    localparam longint GRID = longint'(1) << FRAC_SHIFT;

    logic [3*NORM_W-1:0] normal_q [NUM_PLANES];
    logic [OFFS_W-1:0]   offset_q [NUM_PLANES];
    logic [1:0]          vis_expected_q [$];
    logic [1:0]          want;

    // exact signed distance of a point from plane pl
    function automatic longint plane_distance(int pl, longint px, longint py, longint pz);
        longint nx;
        longint ny;
        longint nz;
        longint d;
        nx = longint'($signed(normal_q[pl][NORM_W-1:0]));
        ny = longint'($signed(normal_q[pl][2*NORM_W-1:NORM_W]));
        nz = longint'($signed(normal_q[pl][3*NORM_W-1:2*NORM_W]));
        d  = longint'($signed(offset_q[pl]));
        return nx * px + ny * py + nz * pz + d * GRID;
    endfunction

    // visibility class of one request
    function automatic logic [1:0] classify(logic [1:0] op,
                                            longint ax, longint ay, longint az,
                                            longint bx, longint by, longint bz,
                                            longint cx, longint cy, longint cz,
                                            longint mg);
        longint    m;
        longint    d;
        logic      out_any;
        logic      all_in;
        fct_code_t code_a;
        fct_code_t code_b;
        fct_code_t code_c;
        m       = mg * GRID;
        out_any = 1'b0;
        all_in  = 1'b1;
        code_a  = '0;
        code_b  = '0;
        code_c  = '0;
        case (op)
            OP_POINT:
            begin
                for (int pl = 0; pl < NUM_PLANES; pl++)
                    if (plane_distance(pl, ax, ay, az) > 0)
                        out_any = 1'b1;
                return out_any ? VIS_OUTSIDE : VIS_INSIDE;
            end
            OP_SPHERE:
            begin
                // radius used as given, negative too
                for (int pl = 0; pl < NUM_PLANES; pl++)
                begin
                    d = plane_distance(pl, ax, ay, az);
                    if (d > m)
                        out_any = 1'b1;
                    if (!(d < -m))
                        all_in = 1'b0;
                end
                if (out_any)
                    return VIS_OUTSIDE;
                return all_in ? VIS_INSIDE : VIS_PARTIAL;
            end
            OP_TRIANGLE:
            begin
                // outcode bit per plane, set when beyond the tolerance
                for (int pl = 0; pl < NUM_PLANES; pl++)
                begin
                    if (plane_distance(pl, ax, ay, az) > m)
                        code_a[pl] = 1'b1;
                    if (plane_distance(pl, bx, by, bz) > m)
                        code_b[pl] = 1'b1;
                    if (plane_distance(pl, cx, cy, cz) > m)
                        code_c[pl] = 1'b1;
                end
                if ((code_a | code_b | code_c) == '0)
                    return VIS_INSIDE;
                if ((code_a & code_b & code_c) != '0)
                    return VIS_OUTSIDE;
                return VIS_PARTIAL;
            end
            default:
                return VIS_OUTSIDE;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int pl = 0; pl < NUM_PLANES; pl++)
            begin
                normal_q[pl] <= '0;
                offset_q[pl] <= '0;
            end
            vis_expected_q.delete();
            fail_count   <= 0;
            pending      <= 0;
            seen_outside <= 0;
            seen_partial <= 0;
            seen_inside  <= 0;
        end
        else
        begin
            // plane register writes; paddr[3] picks normal or offset
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == KIND_NORMAL)
                    normal_q[paddr[5:4]] <= pwdata[3*NORM_W-1:0];
                else
                    offset_q[paddr[5:4]] <= pwdata[OFFS_W-1:0];
            end

            // compare a delivered result with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (vis_expected_q.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, got %0d",
                             $time, result.visibility);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = vis_expected_q.pop_front();
                    if (result.visibility !== want)
                    begin
                        $display("%0t: visibility mismatch, expected %0d, got %0d",
                                 $time, want, result.visibility);
                        fail_count <= fail_count + 1;
                    end
                end
                case (result.visibility)
                    VIS_OUTSIDE: seen_outside <= seen_outside + 1;
                    VIS_PARTIAL: seen_partial <= seen_partial + 1;
                    VIS_INSIDE:  seen_inside  <= seen_inside + 1;
                    default:     ;
                endcase
            end

            // predict each accepted request, appended at the tail
            if (prim.valid && prim.ready)
                vis_expected_q = {vis_expected_q, classify(prim.op,
                    prim.a_x, prim.a_y, prim.a_z,
                    prim.b_x, prim.b_y, prim.b_z,
                    prim.c_x, prim.c_y, prim.c_z,
                    prim.margin)};

            pending <= vis_expected_q.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the frustum cull bench: clock, reset, plane settings, request and result traffic.
module testbench;
    import fct_pkg::*;

    localparam int COORD_BITS      = 24;
    localparam int LATENCY         = 5;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int BOX_SMALL       = 1000;
    localparam int BOX_LARGE       = 3000000;
    localparam int CMAX            = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN            = -(1 << (COORD_BITS - 1));

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [NORM_W-1:0] Q14_ZERO      = 16'h0000;
    localparam logic [NORM_W-1:0] Q14_PLUS_ONE  = 16'h4000;
    localparam logic [NORM_W-1:0] Q14_MINUS_ONE = 16'hC000;
    localparam logic [NORM_W-1:0] Q14_MAX       = 16'h7FFF;
    localparam logic [NORM_W-1:0] Q14_MIN       = 16'h8000;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0] op;
        coord_t     a_x;
        coord_t     a_y;
        coord_t     a_z;
        coord_t     b_x;
        coord_t     b_y;
        coord_t     b_z;
        coord_t     c_x;
        coord_t     c_y;
        coord_t     c_z;
        coord_t     margin;
    } prim_req_t;

    typedef enum int {
        SET_SMALL_BOX,
        SET_LARGE_BOX,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_RANDOM_NEAR,
        SET_RANDOM_FULL,
        NUM_SETTINGS
    } plane_setting_e;

    typedef enum int {
        PH_FREE,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH,
        NUM_PHASES
    } traffic_phase_e;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int   idle_pct = 0;
    int   stall_pct = 0;
    logic long_stall_req = 1'b0;
    int   requests_sent = 0;
    int   quiet_cycles = 0;

    int   fail_count;
    int   pending;
    int   seen_outside;
    int   seen_partial;
    int   seen_inside;

    fct_prim_if #(.COORD_BITS(COORD_BITS)) prim_ch ();
    fct_result_if result_ch ();

    frustum_cull_test_unit #(.COORD_BITS(COORD_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .prim    (prim_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cull_checker watcher (
        .clk          (clk),
        .rst_n        (rst_n),
        .prim         (prim_ch),
        .result       (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .seen_outside (seen_outside),
        .seen_partial (seen_partial),
        .seen_inside  (seen_inside)
    );

    always #4 clk = ~clk;

    // watchdog: too long with nothing moving on any port ends the run
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((prim_ch.valid && prim_ch.ready) || (result_ch.valid && result_ch.ready)
                 || (psel && penable))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: nothing accepted for %0d cycles", $time, quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_stall_req = 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic prim_req_t mk_request(logic [1:0] op,
                                             int ax, int ay, int az,
                                             int bx, int by, int bz,
                                             int cx, int cy, int cz, int mg);
        prim_req_t r;
        r.op     = op;
        r.a_x    = coord_t'(ax);
        r.a_y    = coord_t'(ay);
        r.a_z    = coord_t'(az);
        r.b_x    = coord_t'(bx);
        r.b_y    = coord_t'(by);
        r.b_z    = coord_t'(bz);
        r.c_x    = coord_t'(cx);
        r.c_y    = coord_t'(cy);
        r.c_z    = coord_t'(cz);
        r.margin = coord_t'(mg);
        return r;
    endfunction

    // coordinate scattered round a centre, now and then anywhere in range
    function automatic coord_t near_coord(int centre, int spread);
        if ($urandom_range(99) < 12)
            return coord_t'($urandom());
        return coord_t'(centre + int'($urandom_range(2 * spread)) - spread);
    endfunction

    // random primitive clustered so that all three classes turn up
    function automatic prim_req_t rand_request(int span);
        prim_req_t r;
        int        cen_x;
        int        cen_y;
        int        cen_z;
        int        spread;
        int        pick;
        spread = span / 4 + 1;
        cen_x  = int'($urandom_range(2 * span)) - span;
        cen_y  = int'($urandom_range(2 * span)) - span;
        cen_z  = int'($urandom_range(2 * span)) - span;
        pick   = int'($urandom_range(99));
        if (pick < 30)
            r.op = OP_POINT;
        else if (pick < 60)
            r.op = OP_SPHERE;
        else if (pick < 96)
            r.op = OP_TRIANGLE;
        else
            r.op = OP_UNUSED;
        r.a_x = near_coord(cen_x, spread);
        r.a_y = near_coord(cen_y, spread);
        r.a_z = near_coord(cen_z, spread);
        r.b_x = near_coord(cen_x, spread);
        r.b_y = near_coord(cen_y, spread);
        r.b_z = near_coord(cen_z, spread);
        r.c_x = near_coord(cen_x, spread);
        r.c_y = near_coord(cen_y, spread);
        r.c_z = near_coord(cen_z, spread);
        pick  = int'($urandom_range(99));
        if (pick < 70)
            r.margin = coord_t'($urandom_range(spread));
        else if (pick < 90)
            r.margin = coord_t'(-int'($urandom_range(spread)));
        else
            r.margin = coord_t'($urandom());
        return r;
    endfunction

    // offer one request, with random idle cycles first; returns at a falling edge
    task automatic send_request(input prim_req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            prim_ch.valid <= 1'b0;
            @(negedge clk);
        end
        {prim_ch.op, prim_ch.a_x, prim_ch.a_y, prim_ch.a_z,
         prim_ch.b_x, prim_ch.b_y, prim_ch.b_z,
         prim_ch.c_x, prim_ch.c_y, prim_ch.c_z, prim_ch.margin} <= r;
        prim_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!prim_ch.ready);
        @(negedge clk);
        requests_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        prim_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // setup and access cycles; psel stays high so writes can follow back to back
    task automatic apb_write(input int plane, input logic kind, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({2'(plane), kind, 3'b000});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
    endtask

    // four side planes of an axis-aligned box, |x| and |y| up to half
    task automatic write_box(input int half);
        logic [APB_DW-1:0] offs;
        offs = {32'h0, 32'(-half)};
        apb_write(0, KIND_NORMAL, {16'h0, Q14_ZERO, Q14_ZERO, Q14_PLUS_ONE});
        apb_write(0, KIND_OFFSET, offs);
        apb_write(1, KIND_NORMAL, {16'h0, Q14_ZERO, Q14_ZERO, Q14_MINUS_ONE});
        apb_write(1, KIND_OFFSET, offs);
        apb_write(2, KIND_NORMAL, {16'h0, Q14_ZERO, Q14_PLUS_ONE, Q14_ZERO});
        apb_write(2, KIND_OFFSET, offs);
        apb_write(3, KIND_NORMAL, {16'h0, Q14_ZERO, Q14_MINUS_ONE, Q14_ZERO});
        apb_write(3, KIND_OFFSET, offs);
    endtask

    // write all eight plane registers for one setting
    task automatic load_setting(input plane_setting_e s, output int span);
        case (s)
            SET_SMALL_BOX:
            begin
                write_box(BOX_SMALL);
                span = 2 * BOX_SMALL;
            end
            SET_LARGE_BOX:
            begin
                write_box(BOX_LARGE);
                span = 2 * BOX_LARGE;
            end
            SET_ALL_MAX:
            begin
                for (int pl = 0; pl < NUM_PLANES; pl++)
                begin
                    apb_write(pl, KIND_NORMAL, {16'h0, Q14_MAX, Q14_MAX, Q14_MAX});
                    apb_write(pl, KIND_OFFSET, {32'h0, 32'h7FFF_FFFF});
                end
                span = CMAX;
            end
            SET_ALL_MIN:
            begin
                for (int pl = 0; pl < NUM_PLANES; pl++)
                begin
                    apb_write(pl, KIND_NORMAL, {16'h0, Q14_MIN, Q14_MIN, Q14_MIN});
                    apb_write(pl, KIND_OFFSET, {32'h0, 32'h8000_0000});
                end
                span = CMAX;
            end
            SET_RANDOM_NEAR:
            begin
                // offsets of the same order as the dot products
                for (int pl = 0; pl < NUM_PLANES; pl++)
                begin
                    apb_write(pl, KIND_NORMAL, {16'h0, 16'($urandom), 32'($urandom)});
                    apb_write(pl, KIND_OFFSET,
                              {32'h0, 32'(int'($urandom_range(400000)) - 200000)});
                end
                span = 100000;
            end
            default:
            begin
                for (int pl = 0; pl < NUM_PLANES; pl++)
                begin
                    apb_write(pl, KIND_NORMAL, {16'h0, 16'($urandom), 32'($urandom)});
                    apb_write(pl, KIND_OFFSET, {32'h0, 32'($urandom)});
                end
                span = 100000;
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int span;
        prim_ch.valid = 1'b0;
        {prim_ch.op, prim_ch.a_x, prim_ch.a_y, prim_ch.a_z,
         prim_ch.b_x, prim_ch.b_y, prim_ch.b_z,
         prim_ch.c_x, prim_ch.c_y, prim_ch.c_z, prim_ch.margin} = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // planes still at reset: every distance is zero
        send_request(mk_request(OP_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_request(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_request(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_request(mk_request(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1));
        send_request(mk_request(OP_TRIANGLE, 1, 2, 3, 4, 5, 6, 7, 8, 9, 0));
        send_request(mk_request(OP_TRIANGLE, 1, 2, 3, 4, 5, 6, 7, 8, 9, -1));
        send_request(mk_request(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            load_setting(plane_setting_e'(s), span);

            if (s == SET_SMALL_BOX)
            begin
                // points: inside, on the plane (with junk in unused fields), outside
                send_request(mk_request(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
                send_request(mk_request(OP_POINT, BOX_SMALL, 0, 0,
                                        CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN));
                send_request(mk_request(OP_POINT, BOX_SMALL + 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
                send_request(mk_request(OP_POINT, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, 0, 0));
                // spheres: inside, straddling, touching, outside, negative radius
                send_request(mk_request(OP_SPHERE, 0, 0, 0,
                                        CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 100));
                send_request(mk_request(OP_SPHERE, 950, 0, 0, 0, 0, 0, 0, 0, 0, 100));
                send_request(mk_request(OP_SPHERE, 1100, 0, 0, 0, 0, 0, 0, 0, 0, 100));
                send_request(mk_request(OP_SPHERE, 1200, 0, 0, 0, 0, 0, 0, 0, 0, 100));
                send_request(mk_request(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, -100));
                send_request(mk_request(OP_SPHERE, 950, 0, 0, 0, 0, 0, 0, 0, 0, -100));
                send_request(mk_request(OP_SPHERE, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0, CMAX));
                // triangles: inside, outside one plane, crossing, out but no shared plane
                send_request(mk_request(OP_TRIANGLE, 0, 0, 0, 500, 500, 0, -500, 200, CMAX, 0));
                send_request(mk_request(OP_TRIANGLE, 1500, 0, 0, 2000, -300, 0,
                                        1200, 900, 0, 0));
                send_request(mk_request(OP_TRIANGLE, 0, 0, 0, 1500, 0, 0, 0, 1500, 0, 0));
                send_request(mk_request(OP_TRIANGLE, 1500, 0, 0, -1500, 0, 0, 0, 1500, 0, 0));
                send_request(mk_request(OP_TRIANGLE, 1050, 0, 0, 0, 1050, 0,
                                        -1050, -1050, 0, 100));
                send_request(mk_request(OP_TRIANGLE, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX,
                                        CMIN, CMIN, CMAX, CMIN));
                send_request(mk_request(OP_UNUSED, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                        CMAX, CMAX, CMAX, CMAX));
                wait_drained();
            end

            for (int ph = 0; ph < NUM_PHASES; ph++)
            begin
                case (traffic_phase_e'(ph))
                    PH_FREE:           begin idle_pct = 0;  stall_pct = 0;  end
                    PH_SENDER_IDLE:    begin idle_pct = 72; stall_pct = 0;  end
                    PH_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 72; end
                    default:           begin idle_pct = 18; stall_pct = 18; end
                endcase
                for (int n = 0; n < ITEMS_PER_PHASE; n++)
                begin
                    // long result hold-off while requests keep coming: pipeline fills
                    if (s == SET_SMALL_BOX && ph == PH_FREE && n == 10)
                        long_stall_req = 1'b1;
                    send_request(rand_request(span));
                end
                wait_drained();
            end
        end

        repeat (2 * LATENCY) @(negedge clk);

        $display("Covered %0d requests of all four op codes over %0d plane settings, %0d traffic phases each",
                 requests_sent, int'(NUM_SETTINGS), int'(NUM_PHASES));
        $display("Results seen: %0d outside, %0d partly visible, %0d inside",
                 seen_outside, seen_partial, seen_inside);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_prim_if.sv
rtl/fct_result_if.sv
rtl/fct_dist_pipe.sv
rtl/frustum_cull_test_unit.sv
bench/cull_checker.sv
bench/testbench.sv
